[hdl/fqd_pkg.sv]
// Shared types and constants for the process queue with delete by key.
// Used by fqd_cell and fifo_queue_with_delete_by_key_top; no dependencies.
package fqd_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W            = 16;
  localparam int BURST_W         = 16;
  localparam int PRIO_W          = 8;
  localparam int OCC_W           = 5;

  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_REM  = 2'd2,
    MODE_FIND = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  localparam entry_t ENTRY_ZERO = '0;

  // Control that the top level broadcasts to every cell.
  typedef struct packed {
    logic load;   // capture key match for the accepted transaction
    logic apply;  // commit the operation
    logic enq;
    logic deq;
    logic rem;
  } cell_ctrl_t;

endpackage

[hdl/fifo_queue_with_delete_by_key_top.sv]
// Process queue with enqueue, dequeue, remove by id and find by id.
// The key compare is captured at the accepting edge and the result is registered when the cells
// commit in S_APPLY, held back while an unread result stalls; no new transaction is taken until then.
// Results wait in an output register, so the next transaction can be taken meanwhile.
// Reset (rst, synchronous) empties the queue and drops any pending result.
// Slot contents are not cleared; only slots below the count are ever read.
module fifo_queue_with_delete_by_key_top
  import fqd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         mode,
  input  logic [ID_W-1:0]    proc_id,
  input  logic [BURST_W-1:0] burst,
  input  logic [PRIO_W-1:0]  prio,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic [ID_W-1:0]    out_id,
  output logic [BURST_W-1:0] out_burst,
  output logic [PRIO_W-1:0]  out_prio,
  output logic [OCC_W-1:0]   occupancy
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t          state;
  state_t          state_next;
  mode_t           op;
  entry_t          new_entry;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            in_fire;
  logic            apply_fire;
  cell_ctrl_t      ctrl;
  status_t         res_status;
  entry_t          res_entry;

  entry_t entries [QUEUE_DEPTH];
  logic   seen    [QUEUE_DEPTH+1];
  entry_t sel     [QUEUE_DEPTH+1];

  assign in_fire    = item_valid && !item_stall;
  assign apply_fire = (state == S_APPLY) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op        <= mode_t'(mode);
      new_entry <= '{id: proc_id, burst: burst, prio: prio};
    end
  end

  always_comb begin
    ctrl.load  = in_fire;
    ctrl.apply = apply_fire;
    ctrl.enq   = (op == MODE_ENQ);
    ctrl.deq   = (op == MODE_DEQ) && (count != '0);
    ctrl.rem   = (op == MODE_REM);
  end

  assign seen[0] = 1'b0;
  assign sel[0]  = ENTRY_ZERO;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nbr = ENTRY_ZERO;
    end else begin : g_mid
      assign nbr = entries[i+1];
    end

    // the match is captured at the accepting edge, so compare against the live id
    fqd_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key        (proc_id),
      .count      (count),
      .new_entry  (new_entry),
      .next_entry (nbr),
      .seen_in    (seen[i]),
      .sel_in     (sel[i]),
      .entry      (entries[i]),
      .seen_out   (seen[i+1]),
      .sel_out    (sel[i+1])
    );
  end

  always_comb begin
    res_status = ST_OK;
    res_entry  = ENTRY_ZERO;
    count_next = count;
    case (op)
      MODE_ENQ: begin
        if (count == CW'(QUEUE_DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      MODE_DEQ: begin
        if (count == '0) begin
          res_status = ST_MISS;
        end else begin
          res_entry  = entries[0];
          count_next = count - 1'b1;
        end
      end
      MODE_REM: begin
        if (!seen[QUEUE_DEPTH]) begin
          res_status = ST_MISS;
        end else begin
          count_next = count - 1'b1;
        end
      end
      MODE_FIND: begin
        if (!seen[QUEUE_DEPTH]) begin
          res_status = ST_MISS;
        end else begin
          res_entry = sel[QUEUE_DEPTH];
        end
      end
      default: res_status = ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else if (apply_fire) begin
      count        <= count_next;
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      status    <= res_status;
      out_id    <= res_entry.id;
      out_burst <= res_entry.burst;
      out_prio  <= res_entry.prio;
      occupancy <= OCC_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    apply_fire && (op == MODE_ENQ) && (count != CW'(QUEUE_DEPTH))
      |=> count == $past(count) + 1'b1)
    else $error("accepted enqueue did not grow the queue");

  a_apply_result: assert property (@(posedge clk) disable iff (rst)
    apply_fire |=> result_valid)
    else $error("committed transaction produced no result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_FULL) |-> occupancy == OCC_W'(QUEUE_DEPTH))
    else $error("full status reported on a queue that is not full");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_fire)
    else $error("transaction accepted while previous one is in progress");

endmodule

[hdl/fqd_cell.sv]
// One queue slot: holds an entry, compares it against the key and takes
// part in the head-to-tail first-match chain. Depends on fqd_pkg.
module fqd_cell
  import fqd_pkg::*;
#(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  cell_ctrl_t      ctrl,
  input  logic [ID_W-1:0] key,
  input  logic [CW-1:0]   count,
  input  entry_t          new_entry,
  input  entry_t          next_entry,
  input  logic            seen_in,
  input  entry_t          sel_in,
  output entry_t          entry,
  output logic            seen_out,
  output entry_t          sel_out
);

  logic hit;
  logic first;
  logic wr_new;
  logic shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.load) begin
      hit <= (CW'(IDX) < count) && (entry.id == key);
    end
  end

  assign first    = hit && !seen_in;
  assign seen_out = seen_in || hit;
  assign sel_out  = sel_in | (first ? entry : ENTRY_ZERO);

  assign wr_new = ctrl.enq && (CW'(IDX) == count);
  // advance toward the head on dequeue, or behind the removed entry
  assign shift  = ctrl.deq || (ctrl.rem && seen_out);

  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      if (wr_new) begin
        entry <= new_entry;
      end else if (shift) begin
        entry <= next_entry;
      end
    end
  end

endmodule
